[hw/rtl/rrs_pkg.sv]
package rrs_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_PICK   = 2'd1;
    localparam logic [1:0] MODE_SWITCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_PICK,
        OP_SWITCH,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_enc;

    // lowest set bit of a slot vector
    function automatic t_enc first_set(input logic [SLOT_COUNT-1:0] v);
        t_enc r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/rrs_front.sv]
module rrs_front import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_target_slot,
    input  logic        i_q_full,
    output logic        o_busy,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_push = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    always_comb begin
        n_item.slot = SLOT_W'(i_target_slot);
        case (i_mode)
            MODE_ADD:  n_item.op = OP_ADD;
            MODE_PICK: n_item.op = OP_PICK;
            MODE_SWITCH: begin
                // out-of-range target behaves as a no-op
                n_item.op = (int'(i_target_slot) < SLOT_COUNT) ? OP_SWITCH : OP_NOP;
            end
            default:   n_item.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[hw/rtl/rrs_queue.sv]
module rrs_queue import rrs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/rrs_back.sv]
module rrs_back import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_slot
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    t_item                 r_item;
    logic [SLOT_COUNT-1:0] r_ready;
    logic                  r_cur_valid;
    logic [SLOT_W-1:0]     r_cur;

    logic [SLOT_COUNT-1:0] above_mask;
    t_enc                  enc_free;
    t_enc                  enc_ready;
    t_enc                  enc_above;
    logic [1:0]            n_status;
    logic [SLOT_W-1:0]     n_slot;

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            above_mask[i] = (SLOT_W'(i) > r_cur);
        end
    end

    assign enc_free  = first_set(~r_ready);
    assign enc_ready = first_set(r_ready);
    assign enc_above = first_set(r_ready & above_mask);

    always_comb begin
        n_status = ST_OK;
        n_slot   = '0;
        case (r_item.op)
            OP_ADD: begin
                if (enc_free.found) begin
                    n_slot = enc_free.idx;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_PICK: begin
                // scan past current first, then wrap; current always matches last
                if (r_cur_valid) begin
                    if (enc_above.found) begin
                        n_slot = enc_above.idx;
                    end else if (enc_ready.found) begin
                        n_slot = enc_ready.idx;
                    end else begin
                        n_slot = r_cur;
                    end
                end else if (enc_ready.found) begin
                    n_slot = enc_ready.idx;
                end else begin
                    n_status = ST_NONE;
                end
            end
            OP_SWITCH: n_slot = r_item.slot;
            default:   n_slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            o_done      <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    o_done  <= 1'b1;
                    if (r_item.op == OP_ADD && enc_free.found) begin
                        r_ready[enc_free.idx] <= 1'b1;
                    end
                    if (r_item.op == OP_SWITCH) begin
                        r_cur_valid <= 1'b1;
                        r_cur       <= r_item.slot;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_EXEC) begin
            o_status <= n_status;
            o_slot   <= 5'(n_slot);
        end
    end

endmodule

[hw/rtl/process_slot_round_robin_scheduler.sv]
// A request accepted on start is registered in the front stage, written into the
// queue, popped into the execute sequencer, and its result registered onto o_done.
// Throughput is set by the execute sequencer that owns the slot table, which takes no
// new request until it has finished the last one; a two-entry queue buffers requests ahead of it.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) frees all slots and clears the current slot.
module process_slot_round_robin_scheduler import rrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_mode,
    input  logic [4:0] i_target_slot,
    output logic       o_done,
    output logic [1:0] o_status,
    output logic [4:0] o_slot
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_item front_item;
    t_item q_item;

    rrs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_mode        (i_mode),
        .i_target_slot (i_target_slot),
        .i_q_full      (q_full),
        .o_busy        (busy),
        .o_push        (push),
        .o_item        (front_item)
    );

    rrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    rrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_done    (o_done),
        .o_status  (o_status),
        .o_slot    (o_slot)
    );

endmodule

[hw/rtl/rrs_checker.sv]
module rrs_checker import rrs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [4:0] o_slot
);

    // results never leave back to back
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back results");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_NONE))
        else $error("undefined status code");

    a_err_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_slot == 5'd0))
        else $error("nonzero slot with error status");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("activity right after reset");

    // an accepted request keeps results coming: at most three requests sit
    // ahead of it and each passes through the execute stage in turn
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##[1:12] o_done)
        else $error("result missing");

endmodule

bind process_slot_round_robin_scheduler rrs_checker u_rrs_checker (.*);
